>>> rtl/dfa_pi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfa_pi_pkg: shared types and codes
// Item codes, result codes, register indexes and the structs passed between
// the front end, the walk engine and the top level.
// ----------------------------------------------------------------------------
package dfa_pi_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_TRANS = 2'd0;
  localparam logic [1:0] KIND_ACC   = 2'd1;
  localparam logic [1:0] KIND_EMIT  = 2'd2;

  // Result kinds
  localparam logic [1:0] RES_TRANS = 2'd0;
  localparam logic [1:0] RES_ACC   = 2'd1;
  localparam logic [1:0] RES_START = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_COUNT_A = 3'd0;
  localparam logic [2:0] REG_COUNT_B = 3'd1;
  localparam logic [2:0] REG_START_A = 3'd2;
  localparam logic [2:0] REG_START_B = 3'd3;

  // Machine select
  localparam logic MACH_A = 1'b0;
  localparam logic MACH_B = 1'b1;

  // Classified command handed from front to back
  typedef struct packed {
    logic [1:0] op;
    logic       machine;
    logic [3:0] state;
    logic [7:0] symbol;
    logic [3:0] target;
    logic       flag;
  } cmd_t;

  // Configuration as seen by the walk engine
  typedef struct packed {
    logic [4:0] count_a;
    logic [4:0] count_b;
    logic [3:0] start_a;
    logic [3:0] start_b;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] prod_from;
    logic [7:0] sym;
    logic [7:0] prod_to;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/dfa_pi_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfa_pi_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dfa_pi_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/dfa_pi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfa_pi_front: item intake and classification
// Drops unknown kinds and out-of-range loads, queues the rest (two deep)
// for the walk engine.
// ----------------------------------------------------------------------------
module dfa_pi_front #(
  parameter int STATES  = 16,
  parameter int SYMBOLS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire logic [1:0]        kind,
  input  wire logic              machine,
  input  wire logic [3:0]        from_state,
  input  wire logic [7:0]        symbol,
  input  wire logic [3:0]        to_state,
  input  wire logic              accept_flag,
  output      logic              q_full,
  output      logic              cmd_valid,
  output      dfa_pi_pkg::cmd_t  cmd,
  input  wire logic              cmd_pop
);

  dfa_pi_pkg::cmd_t q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       cnt;
  logic             from_ok;
  logic             sym_ok;
  logic             keep;
  logic             enq;
  logic             deq;

  // Classify the incoming item
  always_comb begin
    from_ok = int'(from_state) < STATES;
    sym_ok  = int'(symbol) < SYMBOLS;
    unique case (kind)
      dfa_pi_pkg::KIND_TRANS: keep = from_ok && sym_ok;
      dfa_pi_pkg::KIND_ACC:   keep = from_ok;
      dfa_pi_pkg::KIND_EMIT:  keep = 1'b1;
      default:                keep = 1'b0;
    endcase
  end

  assign enq       = wr && keep;
  assign deq       = cmd_pop && cmd_valid;
  assign q_full    = cnt == 2'd2;
  assign cmd_valid = cnt != 2'd0;
  assign cmd       = q[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= '{op: kind, machine: machine, state: from_state,
                     symbol: symbol, target: to_state, flag: accept_flag};
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(enq) - 2'(deq);
    end
  end

endmodule
`default_nettype wire

>>> rtl/dfa_pi_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfa_pi_back: table store and product walk engine
// Holds both transition tables and accept bits, runs loads in order and
// scans the product space for the next result on each emit command.
// ----------------------------------------------------------------------------
module dfa_pi_back #(
  parameter int STATES  = 16,
  parameter int SYMBOLS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  input  wire dfa_pi_pkg::cmd_t  cmd,
  output      logic              cmd_pop,
  input  wire dfa_pi_pkg::cfg_t  cfg,
  output      dfa_pi_pkg::res_t  res,
  output      logic              res_valid,
  input  wire logic              res_pop,
  output      logic              clearing
);

  localparam int CLIM  = (STATES < 16) ? STATES : 16;
  localparam int CW    = $clog2(CLIM + 1);
  localparam int SW    = $clog2(STATES);
  localparam int SYW   = $clog2(SYMBOLS + 1);
  localparam int DEPTH = STATES * SYMBOLS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  logic [1:0]        state;
  logic [AW-1:0]     clr_cnt;
  logic [CW-1:0]     walk_a;
  logic [CW-1:0]     walk_b;
  logic [SYW-1:0]    walk_symbol;
  logic              walk_phase;
  logic [STATES-1:0] acc_a;
  logic [STATES-1:0] acc_b;

  logic [CW-1:0]     ca;
  logic [CW-1:0]     cb;
  logic              a_in;
  logic              b_in;
  logic              s_in;
  logic              out_free;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [4:0]        wdata;
  logic              we_a;
  logic              we_b;
  logic [4:0]        rd_a;
  logic [4:0]        rd_b;
  logic              hit_trans;
  logic              hit_acc;
  logic [7:0]        idx_walk;
  logic [7:0]        idx_target;
  logic [7:0]        idx_start;

  // Product index a*count_b+b, kept to 8 bits
  function automatic logic [7:0] prod_idx(input logic [7:0] a, input logic [7:0] b,
                                          input logic [4:0] nb);
    logic [7:0] p;
    p = a * {3'b000, nb};
    return p + b;
  endfunction

  // Effective counts and walk bounds
  always_comb begin
    ca   = (cfg.count_a > 5'(CLIM)) ? CW'(CLIM) : CW'(cfg.count_a);
    cb   = (cfg.count_b > 5'(CLIM)) ? CW'(CLIM) : CW'(cfg.count_b);
    a_in = walk_a < ca;
    b_in = walk_b < cb;
    s_in = walk_symbol < SYW'(SYMBOLS);
  end

  assign clearing = state == ST_CLEAR;
  assign out_free = !res_valid || res_pop;
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid &&
                    ((cmd.op != dfa_pi_pkg::KIND_EMIT) || out_free);

  // Table addressing: clear sweep, loads, and the scan read
  always_comb begin
    raddr = AW'(walk_a) * AW'(SYMBOLS) + AW'(walk_symbol);
    if (clearing) begin
      waddr = clr_cnt;
      wdata = 5'd0;
    end else begin
      waddr = AW'(cmd.state) * AW'(SYMBOLS) + AW'(cmd.symbol);
      wdata = {1'b1, cmd.target};
    end
    we_a = clearing || (cmd_pop && (cmd.op == dfa_pi_pkg::KIND_TRANS) &&
                        (cmd.machine == dfa_pi_pkg::MACH_A));
    we_b = clearing || (cmd_pop && (cmd.op == dfa_pi_pkg::KIND_TRANS) &&
                        (cmd.machine == dfa_pi_pkg::MACH_B));
  end

  dfa_pi_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_table_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_a)
  );

  dfa_pi_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_table_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (AW'(walk_b) * AW'(SYMBOLS) + AW'(walk_symbol)),
    .rdata (rd_b)
  );

  // Hit detection and product indexes
  always_comb begin
    hit_trans  = rd_a[4] && rd_b[4];
    hit_acc    = acc_a[SW'(walk_a)] && acc_b[SW'(walk_b)];
    idx_walk   = prod_idx(8'(walk_a), 8'(walk_b), cfg.count_b);
    idx_target = prod_idx({4'b0000, rd_a[3:0]}, {4'b0000, rd_b[3:0]}, cfg.count_b);
    idx_start  = prod_idx({4'b0000, cfg.start_a}, {4'b0000, cfg.start_b}, cfg.count_b);
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      res <= '{kind: dfa_pi_pkg::RES_TRANS, prod_from: idx_walk,
               sym: 8'(walk_symbol), prod_to: idx_target, last: 1'b0};
    end else if ((state == ST_SCAN) && walk_phase && !a_in) begin
      res <= '{kind: dfa_pi_pkg::RES_START, prod_from: idx_start,
               sym: 8'd0, prod_to: 8'd0, last: 1'b1};
    end else if (state == ST_SCAN) begin
      res <= '{kind: dfa_pi_pkg::RES_ACC, prod_from: idx_walk,
               sym: 8'd0, prod_to: 8'd0, last: 1'b0};
    end
  end

  // Sequencer: clear sweep, command execution and the product walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      walk_a      <= '0;
      walk_b      <= '0;
      walk_symbol <= '0;
      walk_phase  <= 1'b0;
      acc_a       <= '0;
      acc_b       <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (res_pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd.op)
              dfa_pi_pkg::KIND_ACC: begin
                if (cmd.machine == dfa_pi_pkg::MACH_A) begin
                  acc_a[SW'(cmd.state)] <= cmd.flag;
                end else begin
                  acc_b[SW'(cmd.state)] <= cmd.flag;
                end
              end
              dfa_pi_pkg::KIND_EMIT: state <= ST_SCAN;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (!walk_phase) begin
            priority if (!a_in) begin
              walk_phase  <= 1'b1;
              walk_a      <= '0;
              walk_b      <= '0;
              walk_symbol <= '0;
            end else if (!b_in) begin
              walk_b <= '0;
              walk_a <= walk_a + CW'(1);
            end else if (!s_in) begin
              walk_symbol <= '0;
              walk_b      <= walk_b + CW'(1);
            end else begin
              state <= ST_CHECK;
            end
          end else begin
            priority if (!a_in) begin
              walk_phase  <= 1'b0;
              walk_a      <= '0;
              walk_b      <= '0;
              walk_symbol <= '0;
              res_valid   <= 1'b1;
              state       <= ST_IDLE;
            end else if (!b_in) begin
              walk_b <= '0;
              walk_a <= walk_a + CW'(1);
            end else begin
              walk_b <= walk_b + CW'(1);
              if (hit_acc) begin
                res_valid <= 1'b1;
                state     <= ST_IDLE;
              end
            end
          end
        end
        ST_CHECK: begin
          walk_symbol <= walk_symbol + SYW'(1);
          if (hit_trans) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            state <= ST_SCAN;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The table lookup is always preceded by its address cycle
  a_check_follows_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> ($past(state) == ST_SCAN))
    else $error("lookup without address cycle");

  // The result slot is free for the whole walk
  a_walk_slot_free: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) || (state == ST_CHECK)) |-> !res_valid)
    else $error("walk running while result slot occupied");

  // The accept phase never carries a symbol position
  a_phase_symbol: assert property (@(posedge clk) disable iff (rst)
    walk_phase |-> (walk_symbol == '0))
    else $error("symbol position left over in accept phase");

  // No result and no command taken during the clear sweep
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!res_valid && !cmd_pop))
    else $error("activity during clear sweep");
`endif

endmodule
`default_nettype wire

>>> rtl/dfa_product_intersection.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfa_product_intersection: product construction of two partial DFAs
// Loads transitions and accept bits of machines A and B, and returns the
// product machine's transitions, accepting pairs and start pair on emits.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          kind machine from_state symbol to_state
//                                 accept_flag
//  result    empty / pop          result_kind product_from out_symbol
//                                 product_to last_flag
//  config    cfg_valid/cfg_ready  cfg_index cfg_data
//
//  A load is executed by the walk engine as it leaves the two-deep queue.
//  An emit visits each (a, b, symbol) position scanned in the tables with
//  an address step in SCAN and a lookup in CHECK on the registered RAM read,
//  and steps over each row or pair skipped, as each table has a single read
//  port. After reset a clear sweep over all STATES*SYMBOLS entries empties
//  both tables; full stays high for its length. Configuration is always ready.
//  A waiting result never blocks input: items queue until the queue fills.
// ----------------------------------------------------------------------------
module dfa_product_intersection #(
  parameter int STATES  = 16,
  parameter int SYMBOLS = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // input items
  input  wire logic       push,
  output      logic       full,
  input  wire logic [1:0] kind,
  input  wire logic       machine,
  input  wire logic [3:0] from_state,
  input  wire logic [7:0] symbol,
  input  wire logic [3:0] to_state,
  input  wire logic       accept_flag,
  // result items
  output      logic       empty,
  input  wire logic       pop,
  output      logic [1:0] result_kind,
  output      logic [7:0] product_from,
  output      logic [7:0] out_symbol,
  output      logic [7:0] product_to,
  output      logic       last_flag,
  // configuration
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [4:0] cfg_data
);

  dfa_pi_pkg::cfg_t cfg;
  dfa_pi_pkg::cmd_t cmd;
  dfa_pi_pkg::res_t res;
  logic             q_full;
  logic             cmd_valid;
  logic             cmd_pop;
  logic             res_valid;
  logic             clearing;

  assign full      = q_full || clearing;
  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  assign result_kind  = res.kind;
  assign product_from = res.prod_from;
  assign out_symbol   = res.sym;
  assign product_to   = res.prod_to;
  assign last_flag    = res.last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{count_a: 5'd1, count_b: 5'd1, start_a: 4'd0, start_b: 4'd0};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dfa_pi_pkg::REG_COUNT_A: cfg.count_a <= cfg_data;
        dfa_pi_pkg::REG_COUNT_B: cfg.count_b <= cfg_data;
        dfa_pi_pkg::REG_START_A: cfg.start_a <= cfg_data[3:0];
        dfa_pi_pkg::REG_START_B: cfg.start_b <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  dfa_pi_front #(.STATES(STATES), .SYMBOLS(SYMBOLS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .wr          (push && !full),
    .kind        (kind),
    .machine     (machine),
    .from_state  (from_state),
    .symbol      (symbol),
    .to_state    (to_state),
    .accept_flag (accept_flag),
    .q_full      (q_full),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  dfa_pi_back #(.STATES(STATES), .SYMBOLS(SYMBOLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop && res_valid),
    .clearing  (clearing)
  );

endmodule
`default_nettype wire

>>> tb/tb_dfa_product_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dfa_product_intersection: self-checking bench for the DFA product block
// Loads transitions and accept bits of both machines, issues emit items and
// checks every product result against an in-bench model of the walk. Runs a
// directed phase, then random phases over several register settings with
// idle and stall patterns on both queues and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_dfa_product_intersection;

  localparam int STATES       = 16;
  localparam int SYMBOLS      = 256;
  localparam int LONG_HOLD    = 1500;
  localparam int DRAIN_CYCLES = 16;
  localparam int TAIL_CYCLES  = 64;
  localparam int PHASES       = 12;
  localparam int PRESSURE_PH  = 11;

  // kind code the block ignores
  localparam logic [1:0] KIND_NONE = 2'd3;
  // register indexes the block ignores
  localparam logic [2:0] REG_UNUSED_LO = 3'd4;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] kind = '0;
  logic       machine = 1'b0;
  logic [3:0] from_state = '0;
  logic [7:0] symbol = '0;
  logic [3:0] to_state = '0;
  logic       accept_flag = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] product_from;
  logic [7:0] out_symbol;
  logic [7:0] product_to;
  logic       last_flag;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  dfa_product_intersection i_dut (
    .clk, .rst,
    .push, .full, .kind, .machine, .from_state, .symbol, .to_state, .accept_flag,
    .empty, .pop, .result_kind, .product_from, .out_symbol, .product_to, .last_flag,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the product walk
  bit [4:0]    trans_a [STATES][SYMBOLS];  // {valid, target}
  bit [4:0]    trans_b [STATES][SYMBOLS];
  bit          accept_a [STATES];
  bit          accept_b [STATES];
  int unsigned walk_a_pos, walk_b_pos, walk_sym_pos;
  bit          scanning_accepts;
  bit [4:0]    reg_count_a = 5'd1;
  bit [4:0]    reg_count_b = 5'd1;
  bit [3:0]    reg_start_a = 4'd0;
  bit [3:0]    reg_start_b = 4'd0;

  dfa_pi_pkg::cmd_t dfa_items[$];
  dfa_pi_pkg::res_t products_due[$];
  dfa_pi_pkg::cmd_t item_on_bus;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned items_this_phase;
  int unsigned fail_count;
  bit          pop_blocked = 1'b0;
  bit          pressure_armed = 1'b0;
  logic [7:0]  sym_pool [6];
  longint      work_budget;
  longint      cycle_limit = 64'd100000;
  longint      cycle_count;

  function automatic int unsigned scan_count(bit [4:0] c);
    return (int'(c) > STATES) ? STATES : int'(c);
  endfunction

  function automatic logic [7:0] product_index(int unsigned a, int unsigned b);
    int unsigned p;
    p = a * 32'(reg_count_b) + b;
    return p[7:0];
  endfunction

  // Advance the walk to its next result
  function automatic dfa_pi_pkg::res_t next_product_result();
    dfa_pi_pkg::res_t r;
    int unsigned      ca, cb;
    r  = '0;
    ca = scan_count(reg_count_a);
    cb = scan_count(reg_count_b);
    if (!scanning_accepts) begin
      while (walk_a_pos < ca) begin
        while (walk_b_pos < cb) begin
          while (walk_sym_pos < SYMBOLS) begin
            if (trans_a[walk_a_pos][walk_sym_pos][4] &&
                trans_b[walk_b_pos][walk_sym_pos][4]) begin
              r.kind      = dfa_pi_pkg::RES_TRANS;
              r.prod_from = product_index(walk_a_pos, walk_b_pos);
              r.sym       = walk_sym_pos[7:0];
              r.prod_to   = product_index(32'(trans_a[walk_a_pos][walk_sym_pos][3:0]),
                                          32'(trans_b[walk_b_pos][walk_sym_pos][3:0]));
              walk_sym_pos++;
              return r;
            end
            walk_sym_pos++;
          end
          walk_sym_pos = 0;
          walk_b_pos++;
        end
        walk_b_pos = 0;
        walk_a_pos++;
      end
      scanning_accepts = 1'b1;
      walk_a_pos   = 0;
      walk_b_pos   = 0;
      walk_sym_pos = 0;
    end
    while (walk_a_pos < ca) begin
      while (walk_b_pos < cb) begin
        if (accept_a[walk_a_pos] && accept_b[walk_b_pos]) begin
          r.kind      = dfa_pi_pkg::RES_ACC;
          r.prod_from = product_index(walk_a_pos, walk_b_pos);
          walk_b_pos++;
          return r;
        end
        walk_b_pos++;
      end
      walk_b_pos = 0;
      walk_a_pos++;
    end
    // start pair closes the walk
    r.kind           = dfa_pi_pkg::RES_START;
    r.prod_from      = product_index(32'(reg_start_a), 32'(reg_start_b));
    r.last           = 1'b1;
    scanning_accepts = 1'b0;
    walk_a_pos       = 0;
    walk_b_pos       = 0;
    walk_sym_pos     = 0;
    return r;
  endfunction

  function automatic void apply_dfa_item(dfa_pi_pkg::cmd_t it);
    case (it.op)
      dfa_pi_pkg::KIND_TRANS: begin
        if (it.machine == dfa_pi_pkg::MACH_A)
          trans_a[it.state][it.symbol] = {1'b1, it.target};
        else
          trans_b[it.state][it.symbol] = {1'b1, it.target};
      end
      dfa_pi_pkg::KIND_ACC: begin
        if (it.machine == dfa_pi_pkg::MACH_A) accept_a[it.state] = it.flag;
        else                                  accept_b[it.state] = it.flag;
      end
      dfa_pi_pkg::KIND_EMIT: products_due.insert(products_due.size(), next_product_result());
      default: ;
    endcase
  endfunction

  // Driver: offer pending items, apply each accepted one to the model
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) apply_dfa_item(item_on_bus);
      if (dfa_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item_on_bus = dfa_items.pop_front();
        push        <= 1'b1;
        kind        <= item_on_bus.op;
        machine     <= item_on_bus.machine;
        from_state  <= item_on_bus.state;
        symbol      <= item_on_bus.symbol;
        to_state    <= item_on_bus.target;
        accept_flag <= item_on_bus.flag;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: check each popped result against the oldest prediction
  always @(posedge clk) begin
    dfa_pi_pkg::res_t got, due;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got.kind      = result_kind;
        got.prod_from = product_from;
        got.sym       = out_symbol;
        got.prod_to   = product_to;
        got.last      = last_flag;
        if (products_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: kind %0d from %0d sym %0d to %0d last %0b",
                     got.kind, got.prod_from, got.sym, got.prod_to, got.last);
        end else begin
          due = products_due.pop_front();
          if (got !== due) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch: expected kind %0d from %0d sym %0d to %0d last %0b",
                       due.kind, due.prod_from, due.sym, due.prod_to, due.last);
              $display("                 got      kind %0d from %0d sym %0d to %0d last %0b",
                       got.kind, got.prod_from, got.sym, got.prod_to, got.last);
            end
          end
        end
      end
      pop <= !pop_blocked && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long result hold-off while the sender keeps going
  initial begin
    wait (pressure_armed);
    @(posedge clk);
    pop_blocked <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    pop_blocked <= 1'b0;
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Hold valid across back-to-back writes; caller drops it after the batch
  task automatic write_reg(logic [2:0] idx, logic [4:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dfa_pi_pkg::REG_COUNT_A: reg_count_a = data;
      dfa_pi_pkg::REG_COUNT_B: reg_count_b = data;
      dfa_pi_pkg::REG_START_A: reg_start_a = data[3:0];
      dfa_pi_pkg::REG_START_B: reg_start_b = data[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [4:0] ca, logic [4:0] cb, logic [4:0] sa, logic [4:0] sb);
    write_reg(dfa_pi_pkg::REG_COUNT_A, ca);
    write_reg(dfa_pi_pkg::REG_COUNT_B, cb);
    write_reg(dfa_pi_pkg::REG_START_A, sa);
    write_reg(dfa_pi_pkg::REG_START_B, sb);
    write_reg(3'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), 5'($urandom_range(31)));
    cfg_valid <= 1'b0;
  endtask

  // Queue one item and grow the cycle allowance by its worst case
  task automatic queue_item(logic [1:0] k, logic m, logic [3:0] fs, logic [7:0] sy,
                            logic [3:0] ts, logic fl);
    dfa_pi_pkg::cmd_t it;
    longint           ea, eb;
    it.op      = k;
    it.machine = m;
    it.state   = fs;
    it.symbol  = sy;
    it.target  = ts;
    it.flag    = fl;
    dfa_items.insert(dfa_items.size(), it);
    if (k != KIND_NONE) items_this_phase++;
    ea = longint'(scan_count(reg_count_a));
    eb = longint'(scan_count(reg_count_b));
    if (k == dfa_pi_pkg::KIND_EMIT)
      work_budget += 2 * SYMBOLS * ea * eb + ea * eb + ea + 40;
    else
      work_budget += 24;
    cycle_limit = 4 * work_budget + 20000;
  endtask

  // Loads are mostly inside the counts over a small symbol set, so that joint
  // transitions are common; besides emits, the rest is noise over the full field ranges
  task automatic queue_random_item();
    int unsigned r, m, top;
    r   = $urandom_range(99);
    m   = $urandom_range(1);
    top = scan_count(m ? reg_count_b : reg_count_a);
    top = (top == 0) ? 0 : top - 1;
    if (r < 35)
      queue_item(dfa_pi_pkg::KIND_TRANS, 1'(m), 4'($urandom_range(top)),
                 sym_pool[$urandom_range(5)],
                 ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(top)),
                 1'($urandom_range(1)));
    else if (r < 47)
      queue_item(dfa_pi_pkg::KIND_ACC, 1'(m), 4'($urandom_range(top)),
                 8'($urandom_range(255)), 4'($urandom_range(15)),
                 $urandom_range(9) < 7);
    else if (r < 77)
      queue_item(dfa_pi_pkg::KIND_EMIT, 1'(m), 4'($urandom_range(15)),
                 8'($urandom_range(255)), 4'($urandom_range(15)),
                 1'($urandom_range(1)));
    else if (r < 87)
      queue_item(dfa_pi_pkg::KIND_TRANS, 1'(m), 4'($urandom_range(15)),
                 8'($urandom_range(255)), 4'($urandom_range(15)),
                 1'($urandom_range(1)));
    else if (r < 94)
      queue_item(dfa_pi_pkg::KIND_ACC, 1'(m), 4'($urandom_range(15)),
                 8'($urandom_range(255)), 4'($urandom_range(15)),
                 1'($urandom_range(1)));
    else
      queue_item(KIND_NONE, 1'(m), 4'($urandom_range(15)),
                 8'($urandom_range(255)), 4'($urandom_range(15)),
                 1'($urandom_range(1)));
  endtask

  // Wait until every item is in and every result is out, then let loads drain;
  // sample between edges so the driver's update of this edge is seen
  task automatic settle();
    do @(negedge clk);
    while (dfa_items.size() != 0 || push || products_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned ph, n_items;
    work_budget   = longint'(STATES * SYMBOLS + LONG_HOLD);
    cycle_limit   = 4 * work_budget + 20000;
    send_idle_pct = 15;
    recv_idle_pct = 70;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every kind, states and targets beyond the
    // counts, and loads landing in the middle of a walk
    configure(5'd2, 5'd3, 5'd1, 5'd2);
    queue_item(dfa_pi_pkg::KIND_TRANS, dfa_pi_pkg::MACH_A, 4'd0,  8'd0,   4'd1,  1'b0);
    queue_item(dfa_pi_pkg::KIND_TRANS, dfa_pi_pkg::MACH_B, 4'd0,  8'd0,   4'd2,  1'b0);
    queue_item(dfa_pi_pkg::KIND_TRANS, dfa_pi_pkg::MACH_A, 4'd1,  8'd255, 4'd15, 1'b0);
    queue_item(dfa_pi_pkg::KIND_TRANS, dfa_pi_pkg::MACH_B, 4'd2,  8'd255, 4'd0,  1'b0);
    queue_item(dfa_pi_pkg::KIND_TRANS, dfa_pi_pkg::MACH_A, 4'd15, 8'd7,   4'd3,  1'b1);
    queue_item(dfa_pi_pkg::KIND_TRANS, dfa_pi_pkg::MACH_B, 4'd15, 8'd7,   4'd15, 1'b1);
    queue_item(dfa_pi_pkg::KIND_ACC,   dfa_pi_pkg::MACH_A, 4'd1,  8'd0,   4'd0,  1'b1);
    queue_item(dfa_pi_pkg::KIND_ACC,   dfa_pi_pkg::MACH_B, 4'd2,  8'd0,   4'd0,  1'b1);
    queue_item(dfa_pi_pkg::KIND_ACC,   dfa_pi_pkg::MACH_B, 4'd0,  8'd0,   4'd0,  1'b1);
    queue_item(dfa_pi_pkg::KIND_ACC,   dfa_pi_pkg::MACH_A, 4'd15, 8'd255, 4'd15, 1'b1);
    queue_item(KIND_NONE,              dfa_pi_pkg::MACH_B, 4'd15, 8'd255, 4'd15, 1'b1);
    queue_item(dfa_pi_pkg::KIND_EMIT,  dfa_pi_pkg::MACH_A, 4'd0,  8'd0,   4'd0,  1'b0);
    queue_item(dfa_pi_pkg::KIND_EMIT,  dfa_pi_pkg::MACH_B, 4'd15, 8'd255, 4'd15, 1'b1);
    repeat (4)
      queue_item(dfa_pi_pkg::KIND_EMIT, dfa_pi_pkg::MACH_A, 4'd0, 8'd0, 4'd0, 1'b0);
    queue_item(dfa_pi_pkg::KIND_ACC,   dfa_pi_pkg::MACH_A, 4'd1,  8'd0,   4'd0,  1'b0);
    queue_item(dfa_pi_pkg::KIND_TRANS, dfa_pi_pkg::MACH_B, 4'd0,  8'd255, 4'd14, 1'b0);
    repeat (3)
      queue_item(dfa_pi_pkg::KIND_EMIT, dfa_pi_pkg::MACH_A, 4'd0, 8'd0, 4'd0, 1'b0);
    settle();

    // Random phases
    for (ph = 1; ph <= PHASES; ph++) begin
      if (ph <= 4) begin
        send_idle_pct = 15;
        recv_idle_pct = 70;
      end else if (ph <= 8) begin
        send_idle_pct = 70;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n_items = 180;
      case (ph)
        3: begin
          configure(5'd0, 5'd31, 5'd31, 5'd31);
          n_items = 60;
        end
        6: begin
          configure(5'd31, 5'd1, 5'd15, 5'd0);
          n_items = 60;
        end
        9: begin
          configure(5'd1, 5'd31, 5'd0, 5'd16);
          n_items = 60;
        end
        default: configure(5'($urandom_range(3, 1)), 5'($urandom_range(4, 1)),
                           5'($urandom_range(31)), 5'($urandom_range(31)));
      endcase
      if (ph == PRESSURE_PH) pressure_armed = 1'b1;
      foreach (sym_pool[i]) sym_pool[i] = 8'($urandom_range(255));
      items_this_phase = 0;
      while (items_this_phase < n_items) queue_random_item();
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && products_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
